>>> rtl/cncc_pkg.sv
// Package with the sequencer state type, fixed widths, configuration indices and operation codes of the classifier.
`timescale 1ns / 1ps
package cncc_pkg;

  localparam int ValW = 16;
  localparam int CfgW = 16;

  localparam logic CfgClassCount = 1'b0;
  localparam logic CfgMinSim     = 1'b1;

  localparam logic OpCentroid = 1'b0;
  localparam logic OpQuery    = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QNORM,
    ST_QSQRT,
    ST_CLASS,
    ST_ACC,
    ST_CSQRT,
    ST_MUL,
    ST_DIV,
    ST_PICK,
    ST_OUT
  } state_e;

endpackage

>>> rtl/cosine_nearest_centroid_classifier.sv
// Top level of the cosine nearest-centroid classifier.
//
// Input channel: one item is a centroid element write (operation 0) or a
// query element (operation 1). Items are accepted when in_valid_i is high and
// in_stall_o is low. A centroid write or a query element without
// last_element leaves the block idle, so such items can follow back to back.
// A query element with last_element starts a classification that runs through
// one accumulator, one bit-serial square root and one bit-serial divider:
// the query norm and its root, then for each active class a setup step, the
// accumulation, the root, a multiply and the divide steps, then the pick and
// output states present the result. The input is stalled meanwhile.
// One result item leaves on the output channel; while the receiver stalls
// the result is held and the block takes no new item.
// Reset clears the control state and the configuration registers (class_count 0,
// min_similarity 0.75). The centroid table and query vector are not cleared;
// every element used must be written first.
`timescale 1ns / 1ps
module cosine_nearest_centroid_classifier
  import cncc_pkg::*;
#(
  parameter int FEATURES    = 16,
  parameter int MAX_CLASSES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [3:0]             class_index_i,
  input  logic [3:0]             feature_index_i,
  input  logic signed [15:0]     feature_value_i,
  input  logic                   last_element_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   class_found_o,
  output logic [3:0]             best_class_o,
  output logic signed [15:0]     similarity_o
);

  localparam int FW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int FCW = $clog2(FEATURES + 1);
  localparam int CCW = $clog2(MAX_CLASSES + 1);
  localparam int DEPTH = MAX_CLASSES * FEATURES;
  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Sum of squares width: 31 bits per square plus growth.
  localparam int SW  = 31 + FCW;
  localparam int RW  = (SW + 1) / 2;     // root width
  localparam int DW  = 2 * RW;            // product of roots
  localparam int NW  = SW + 17;           // |dot|*32768 + d/2
  localparam int QW  = 17;                // quotient bits kept (saturates)
  localparam int SQN = RW;                // root steps

  state_e state_q, state_d;

  logic [4:0]              class_count_q;
  logic signed [15:0]      min_sim_q;

  logic signed [15:0]      cmem [DEPTH];
  logic signed [15:0]      qvec_q [FEATURES];
  logic signed [15:0]      crd_q;

  logic [FCW-1:0]          fcnt_q;
  logic [CCW-1:0]          ccnt_q;
  logic [CCW-1:0]          nact_q;
  logic [6:0]              step_q;

  logic signed [SW:0]      dot_q;
  logic [SW-1:0]           nrm_q;
  logic [SW-1:0]           srem_q;
  logic [RW-1:0]           root_q;
  logic [RW-1:0]           qroot_q;
  logic                    qzero_q;
  logic [DW-1:0]           den_q;
  logic [NW-1:0]           num_q;
  logic [NW:0]             drem_q;
  logic [QW-1:0]           quo_q;
  logic                    neg_q;
  logic                    czero_q;

  logic signed [16:0]      best_q;
  logic [3:0]              bestc_q;
  logic                    have_q;

  logic                    in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // Handshake outputs from the sequencer state.
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_count_q <= '0;
      min_sim_q     <= 16'sd24576;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgClassCount: class_count_q <= cfg_data_i[4:0];
        CfgMinSim:     min_sim_q     <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Centroid memory: one write port, one registered read port.
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  assign wr_en = in_acc && (operation_i == OpCentroid) &&
                 (32'(class_index_i) < MAX_CLASSES) &&
                 (32'(feature_index_i) < FEATURES);
  assign wr_addr = AW'(32'(class_index_i) * FEATURES + 32'(feature_index_i));
  assign rd_addr = AW'(32'(ccnt_q) * FEATURES + 32'(fcnt_q));

  always_ff @(posedge clk_i) begin
    if (wr_en) cmem[wr_addr] <= feature_value_i;
    crd_q <= cmem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OpQuery &&
        (32'(feature_index_i) < FEATURES))
      qvec_q[feature_index_i[FW-1:0]] <= feature_value_i;
  end

  // Shared squarer: query elements during the query norm, centroid
  // elements during accumulation.
  logic signed [15:0] qel;
  logic signed [15:0] sq_op;
  logic signed [31:0] sq;
  assign qel   = qvec_q[fcnt_q[FW-1:0]];
  assign sq_op = (state_q == ST_QNORM) ? qel : crd_q;
  assign sq    = sq_op * sq_op;

  // Products use the previous element pair, aligned to the memory read.
  logic signed [31:0] prod_d;
  logic [FCW-1:0]     fprev;
  assign fprev  = fcnt_q - 1'b1;
  assign prod_d = qvec_q[fprev[FW-1:0]] * crd_q;

  // Square root trial: remainder window vs 4*root+1.
  logic [SW+1:0] srw;
  logic [RW+1:0] strial;
  logic [SW+1:0] s_sub;
  logic          s_ge;
  assign srw    = {srem_q, nrm_q[SW-1 -: 2]};
  assign strial = {root_q, 2'b01};
  assign s_ge   = srw >= {{(SW-RW){1'b0}}, strial};
  assign s_sub  = srw - {{(SW-RW){1'b0}}, strial};

  // Magnitude of the dot product and product of the two roots.
  logic [SW-1:0] mag;
  logic [DW-1:0] rprod;
  assign mag   = dot_q[SW] ? SW'(-dot_q) : SW'(dot_q);
  assign rprod = DW'(qroot_q) * DW'(root_q);

  // Divider step and the final quotient after the last step.
  logic [NW:0]        dshift;
  logic [NW:0]        dsub;
  logic               dge;
  logic [QW-1:0]      qfin_last;
  logic signed [16:0] sim_last;
  assign dshift = {drem_q[NW-1:0], num_q[NW-1]};
  assign dge  = dshift >= {{(NW+1-DW){1'b0}}, den_q};
  assign dsub = dge ? dshift - {{(NW+1-DW){1'b0}}, den_q} : dshift;
  assign qfin_last = {quo_q[QW-2:0], dge};
  always_comb begin
    if (qzero_q || czero_q) sim_last = '0;
    else if (neg_q)
      sim_last = (qfin_last > QW'(32768)) ? -17'sd32768
                                          : -$signed({1'b0, qfin_last[15:0]});
    else
      sim_last = (qfin_last > QW'(32767)) ? 17'sd32767
                                          : $signed({1'b0, qfin_last[15:0]});
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc && operation_i == OpQuery && last_element_i)
                  state_d = ST_QNORM;
      ST_QNORM: if (fcnt_q == FCW'(FEATURES - 1)) state_d = ST_QSQRT;
      ST_QSQRT: if (step_q == 7'(SQN - 1)) state_d = ST_CLASS;
      ST_CLASS: state_d = (ccnt_q == nact_q) ? ST_PICK : ST_ACC;
      ST_ACC:   if (fcnt_q == FCW'(FEATURES)) state_d = ST_CSQRT;
      ST_CSQRT: if (step_q == 7'(SQN - 1)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (step_q == 7'(NW - 1)) state_d = ST_CLASS;
      ST_PICK:  state_d = ST_OUT;
      ST_OUT:   if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Counters and the found flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q  <= '0;
      ccnt_q  <= '0;
      step_q  <= '0;
      have_q  <= 1'b0;
      nact_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          fcnt_q <= '0;
          ccnt_q <= '0;
          step_q <= '0;
          have_q <= 1'b0;
          nact_q <= (32'(class_count_q) > MAX_CLASSES) ? CCW'(MAX_CLASSES)
                                                       : CCW'(class_count_q);
        end
        ST_QNORM: begin
          fcnt_q <= (fcnt_q == FCW'(FEATURES - 1)) ? '0 : fcnt_q + 1'b1;
        end
        ST_QSQRT, ST_CSQRT: begin
          step_q <= (step_q == 7'(SQN - 1)) ? '0 : step_q + 1'b1;
        end
        ST_CLASS: fcnt_q <= '0;
        ST_ACC:   fcnt_q <= (fcnt_q == FCW'(FEATURES)) ? '0 : fcnt_q + 1'b1;
        ST_DIV: begin
          if (step_q == 7'(NW - 1)) begin
            step_q <= '0;
            ccnt_q <= ccnt_q + 1'b1;
            if (sim_last > best_q) have_q <= 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: accumulator, bit-serial root, bit-serial divider, compare.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        nrm_q  <= '0;
        best_q <= -17'sd32768;
        bestc_q <= '0;
      end
      ST_QNORM: begin
        nrm_q  <= nrm_q + SW'(unsigned'(sq));
        srem_q <= '0;
        root_q <= '0;
      end
      ST_QSQRT, ST_CSQRT: begin
        srem_q <= s_ge ? SW'(s_sub) : SW'(srw);
        root_q <= {root_q[RW-2:0], s_ge};
        nrm_q  <= {nrm_q[SW-3:0], 2'b00};
        if (state_q == ST_QSQRT && step_q == 7'(SQN - 1))
          qroot_q <= {root_q[RW-2:0], s_ge};
      end
      ST_CLASS: begin
        dot_q <= '0;
        nrm_q <= '0;
      end
      ST_ACC: begin
        // The registered memory read lags the counter, so the first step adds nothing.
        if (fcnt_q != '0) begin
          dot_q <= dot_q + (SW+1)'(prod_d);
          nrm_q <= nrm_q + SW'(unsigned'(sq));
        end
        srem_q <= '0;
        root_q <= '0;
      end
      ST_MUL: begin
        // Rounded quotient: (|dot|*32768 + d/2) / d.
        den_q  <= rprod;
        neg_q  <= dot_q[SW];
        num_q  <= NW'({mag, 15'b0}) + NW'(rprod >> 1);
        drem_q <= '0;
        quo_q  <= '0;
      end
      ST_DIV: begin
        drem_q <= dsub;
        num_q  <= {num_q[NW-2:0], 1'b0};
        quo_q  <= qfin_last;
        if (step_q == 7'(NW - 1) && sim_last > best_q) begin
          best_q  <= sim_last;
          bestc_q <= 4'(ccnt_q);
        end
      end
      default: ;
    endcase
  end

  // Zero-norm flags (sum of squares at most one).
  always_ff @(posedge clk_i) begin
    if (state_q == ST_QNORM && fcnt_q == FCW'(FEATURES - 1))
      qzero_q <= (nrm_q + SW'(unsigned'(sq))) <= SW'(1);
    if (state_q == ST_ACC && fcnt_q == FCW'(FEATURES))
      czero_q <= (nrm_q + SW'(unsigned'(sq))) <= SW'(1);
  end

  // Result.
  logic found;
  assign found = have_q && (best_q >= 17'(min_sim_q));
  assign class_found_o = found;
  assign best_class_o  = found ? bestc_q : 4'd0;
  assign similarity_o  = found ? best_q[15:0] : 16'sd0;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && class_found_o |-> 32'(best_class_o) < MAX_CLASSES)
    else $error("class out of range");
`endif

endmodule
